// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked once reset is released
`define CLC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked once reset is released
`define CLC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/clc_pkg.sv =====
package clc_pkg;

	// operating modes
	localparam logic [2:0] MODE_OFF   = 3'd0;
	localparam logic [2:0] MODE_INIT  = 3'd1;
	localparam logic [2:0] MODE_RUN   = 3'd2;
	localparam logic [2:0] MODE_ERR   = 3'd3;
	localparam logic [2:0] MODE_EMERG = 3'd4;

	// what the last stage does with the held fan speed
	localparam logic [1:0] SPD_HOLD = 2'd0;
	localparam logic [1:0] SPD_ZERO = 2'd1;
	localparam logic [1:0] SPD_FULL = 2'd2;
	localparam logic [1:0] SPD_PID  = 2'd3;

	// configuration register indexes
	localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
	localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
	localparam logic [2:0] REG_DERIV_GAIN  = 3'd2;
	localparam logic [2:0] REG_TARGET_TEMP = 3'd3;
	localparam logic [2:0] REG_FAN_START   = 3'd4;
	localparam logic [2:0] REG_FAN_HYST    = 3'd5;
	localparam logic [2:0] REG_MAX_TEMP    = 3'd6;
	localparam logic [2:0] REG_CRIT_TEMP   = 3'd7;

	// tick limits
	localparam logic [7:0] INIT_TICKS      = 8'd20;
	localparam logic [7:0] LOW_LEVEL_TICKS = 8'd30;
	localparam logic [7:0] OVER_TEMP_TICKS = 8'd100;

	localparam logic signed [14:0] INTEG_LIMIT = 15'sd5000;

	localparam logic [6:0] SPEED_MAX = 7'd100;
	// 101 * 25600: smallest raw sum that saturates the speed
	localparam logic signed [39:0] SUM_CAP = 40'sd2585600;
	// ceil(2^19 / 100), exact for quotients up to 100
	localparam logic [12:0] RECIP_100 = 13'd5243;

	typedef struct packed {
		logic        [15:0] prop_gain;
		logic        [15:0] integ_gain;
		logic        [15:0] deriv_gain;
		logic signed [11:0] target_temp;
		logic signed [11:0] fan_on_temp;
		logic        [8:0]  fan_band;
		logic signed [11:0] max_temp;
		logic signed [11:0] critical_temp;
	} cfg_t;

	typedef struct packed {
		logic       pump;
		logic       fan;
		logic [2:0] mode;
		logic [1:0] spd_op;
	} ctl_t;

	typedef struct packed {
		logic signed [16:0] err10;
		logic signed [13:0] acc;
		logic signed [20:0] derr100;
	} pid_in_t;

	function automatic logic [7:0] sat_inc(logic [7:0] c);
		return (c == 8'hFF) ? c : c + 8'd1;
	endfunction

endpackage

// ===== rtl/clc_mode_fsm.sv =====
module clc_mode_fsm (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic signed [11:0]     temperature,
	input  logic                   level_ok,
	input  logic                   ignition_on,
	input  clc_pkg::cfg_t          cfg,
	output clc_pkg::ctl_t          ctl,
	output clc_pkg::pid_in_t       pid_in
);
	import clc_pkg::*;

	logic [2:0]         mode_q, mode_n;
	logic               pump_q, pump_n;
	logic               fan_q, fan_n;
	logic signed [13:0] integ_q, integ_n;
	logic signed [12:0] prev_q, prev_n;
	logic [7:0]         pump_ticks_q, pump_ticks_n;
	logic               low_armed_q, low_armed_n;
	logic [7:0]         low_ticks_q, low_ticks_n, low_t;
	logic               hot_armed_q, hot_armed_n;
	logic [7:0]         hot_ticks_q, hot_ticks_n, hot_t;
	logic [1:0]         spd_op;
	logic               safe;

	logic signed [12:0] err;
	logic signed [14:0] acc_raw;
	logic signed [13:0] acc_clamp;
	logic signed [13:0] derr;
	logic signed [12:0] fan_off_lim;
	logic signed [12:0] temp13;

	assign temp13      = 13'(temperature);
	assign err         = temp13 - 13'(cfg.target_temp);
	assign acc_raw     = 15'(integ_q) + 15'(err);
	assign derr        = 14'(err) - 14'(prev_q);
	assign fan_off_lim = 13'(cfg.fan_on_temp) - $signed({4'b0000, cfg.fan_band});

	always_comb begin
		if (acc_raw > INTEG_LIMIT) begin
			acc_clamp = 14'(INTEG_LIMIT);
		end else if (acc_raw < -INTEG_LIMIT) begin
			acc_clamp = 14'(-INTEG_LIMIT);
		end else begin
			acc_clamp = acc_raw[13:0];
		end
	end

	// armed timers advance every tick, whatever the mode
	assign low_t = low_armed_q ? sat_inc(low_ticks_q) : low_ticks_q;
	assign hot_t = hot_armed_q ? sat_inc(hot_ticks_q) : hot_ticks_q;

	always_comb begin
		mode_n       = mode_q;
		pump_n       = pump_q;
		fan_n        = fan_q;
		integ_n      = integ_q;
		prev_n       = prev_q;
		pump_ticks_n = pump_ticks_q;
		low_armed_n  = low_armed_q;
		low_ticks_n  = low_t;
		hot_armed_n  = hot_armed_q;
		hot_ticks_n  = hot_t;
		spd_op       = SPD_HOLD;
		safe         = 1'b1;
		unique case (mode_q)
			MODE_INIT: begin
				if (!level_ok) begin
					mode_n = MODE_ERR;
				end else begin
					if (!pump_q) begin
						pump_n       = 1'b1;
						pump_ticks_n = 8'd0;
					end else begin
						pump_ticks_n = sat_inc(pump_ticks_q);
					end
					if (pump_ticks_n > INIT_TICKS) begin
						mode_n = MODE_RUN;
					end
				end
			end
			MODE_RUN: begin
				if (!ignition_on) begin
					mode_n = MODE_OFF;
				end else begin
					if (!level_ok) begin
						if (!low_armed_q) begin
							low_armed_n = 1'b1;
							low_ticks_n = 8'd0;
						end else if (low_t > LOW_LEVEL_TICKS) begin
							mode_n = MODE_ERR;
							safe   = 1'b0;
						end
					end else begin
						low_armed_n = 1'b0;
					end
					if (safe) begin
						if (temperature > cfg.critical_temp) begin
							mode_n = MODE_EMERG;
							safe   = 1'b0;
						end else if (temperature > cfg.max_temp) begin
							if (!hot_armed_q) begin
								hot_armed_n = 1'b1;
								hot_ticks_n = 8'd0;
							end else if (hot_t > OVER_TEMP_TICKS) begin
								mode_n = MODE_ERR;
								safe   = 1'b0;
							end
						end else begin
							hot_armed_n = 1'b0;
						end
					end
					if (safe) begin
						pump_n = 1'b1;
						if (temperature > cfg.fan_on_temp) begin
							fan_n   = 1'b1;
							spd_op  = SPD_PID;
							integ_n = acc_clamp;
							prev_n  = err;
						end else if (temp13 < fan_off_lim) begin
							fan_n   = 1'b0;
							spd_op  = SPD_ZERO;
							integ_n = '0;
							prev_n  = '0;
						end
					end
				end
			end
			MODE_ERR: begin
				pump_n = 1'b0;
				fan_n  = 1'b0;
				spd_op = SPD_ZERO;
				if (level_ok && temperature < cfg.max_temp) begin
					mode_n = ignition_on ? MODE_INIT : MODE_OFF;
				end
			end
			MODE_EMERG: begin
				pump_n = 1'b0;
				fan_n  = 1'b1;
				spd_op = SPD_FULL;
				if (temperature < cfg.max_temp) begin
					mode_n = MODE_ERR;
				end
			end
			default: begin
				// off, and any code that cannot arise
				pump_n = 1'b0;
				fan_n  = 1'b0;
				spd_op = SPD_ZERO;
				mode_n = ignition_on ? MODE_INIT : MODE_OFF;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_OFF;
			pump_q       <= 1'b0;
			fan_q        <= 1'b0;
			integ_q      <= '0;
			prev_q       <= '0;
			pump_ticks_q <= '0;
			low_armed_q  <= 1'b0;
			low_ticks_q  <= '0;
			hot_armed_q  <= 1'b0;
			hot_ticks_q  <= '0;
		end else if (step) begin
			mode_q       <= mode_n;
			pump_q       <= pump_n;
			fan_q        <= fan_n;
			integ_q      <= integ_n;
			prev_q       <= prev_n;
			pump_ticks_q <= pump_ticks_n;
			low_armed_q  <= low_armed_n;
			low_ticks_q  <= low_ticks_n;
			hot_armed_q  <= hot_armed_n;
			hot_ticks_q  <= hot_ticks_n;
		end
	end

	assign ctl.pump   = pump_n;
	assign ctl.fan    = fan_n;
	assign ctl.mode   = mode_n;
	assign ctl.spd_op = spd_op;

	assign pid_in.err10   = 17'(err) * 17'sd10;
	assign pid_in.acc     = acc_clamp;
	assign pid_in.derr100 = 21'(derr) * 21'sd100;

endmodule

// ===== rtl/clc_pid_dp.sv =====
module clc_pid_dp (
	input  logic             clk,
	input  logic             ld_s3,
	input  logic             ld_s4,
	input  clc_pkg::cfg_t    cfg,
	input  clc_pkg::pid_in_t pid_in,
	output logic [6:0]       pid_speed
);
	import clc_pkg::*;

	logic signed [16:0] kp, ki, kd;
	logic signed [33:0] prod_p_s3;
	logic signed [30:0] prod_i_s3;
	logic signed [37:0] prod_d_s3;
	logic signed [39:0] sum_s4;
	logic [13:0]        coarse;
	logic [26:0]        quot_prod;
	logic               positive, capped;

	assign kp = $signed({1'b0, cfg.prop_gain});
	assign ki = $signed({1'b0, cfg.integ_gain});
	assign kd = $signed({1'b0, cfg.deriv_gain});

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			prod_p_s3 <= kp * pid_in.err10;
			prod_i_s3 <= ki * pid_in.acc;
			prod_d_s3 <= kd * pid_in.derr100;
		end
		if (ld_s4) begin
			sum_s4 <= 40'(prod_p_s3) + 40'(prod_i_s3) + 40'(prod_d_s3);
		end
	end

	// divide by 25600: drop 8 bits, then divide by 100 via reciprocal
	assign positive  = sum_s4 > 40'sd0;
	assign capped    = sum_s4 >= SUM_CAP;
	assign coarse    = sum_s4[21:8];
	assign quot_prod = 27'(coarse) * 27'(RECIP_100);

	always_comb begin
		if (!positive) begin
			pid_speed = 7'd0;
		end else if (capped) begin
			pid_speed = SPEED_MAX;
		end else begin
			pid_speed = quot_prod[25:19];
		end
	end

endmodule

// ===== rtl/coolant_loop_controller.sv =====
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    temperature, level_ok, ignition_on
// out      output     out_valid / out_ready  pump_on, fan_on, fan_speed, mode
// cfg      input      cfg_we                 cfg_index, cfg_data
//
// one word per clock sustained while out_ready stays high; an accepted word passes
// the input reg, mode stage, gain products, sum and result registers to the output
// the mode machine and pid state update as a word leaves the input register,
// so the stage one loop sets the rate of one word per cycle
// each stage stalls only when the stage after it is full and held
// arst_n clears the mode machine, timers, pid state, held speed, valid bits
// and loads the default gains and temperature limits

`include "assert_macros.svh"

module coolant_loop_controller (
	input  logic              clk,
	input  logic              arst_n,
	// input words
	input  logic              in_valid,
	output logic              in_ready,
	input  logic signed [11:0] temperature,
	input  logic              level_ok,
	input  logic              ignition_on,
	// result words
	output logic              out_valid,
	input  logic              out_ready,
	output logic              pump_on,
	output logic              fan_on,
	output logic [6:0]        fan_speed,
	output logic [2:0]        mode,
	// configuration writes
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	import clc_pkg::*;

	// configuration registers
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain     <= 16'd640;
			cfg_q.integ_gain    <= 16'd128;
			cfg_q.deriv_gain    <= 16'd26;
			cfg_q.target_temp   <= 12'sd650;
			cfg_q.fan_on_temp   <= 12'sd600;
			cfg_q.fan_band      <= 9'd50;
			cfg_q.max_temp      <= 12'sd750;
			cfg_q.critical_temp <= 12'sd850;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROP_GAIN:   cfg_q.prop_gain     <= cfg_data;
				REG_INTEG_GAIN:  cfg_q.integ_gain    <= cfg_data;
				REG_DERIV_GAIN:  cfg_q.deriv_gain    <= cfg_data;
				REG_TARGET_TEMP: cfg_q.target_temp   <= $signed(cfg_data[11:0]);
				REG_FAN_START:   cfg_q.fan_on_temp   <= $signed(cfg_data[11:0]);
				REG_FAN_HYST:    cfg_q.fan_band      <= cfg_data[8:0];
				REG_MAX_TEMP:    cfg_q.max_temp      <= $signed(cfg_data[11:0]);
				REG_CRIT_TEMP:   cfg_q.critical_temp <= $signed(cfg_data[11:0]);
				default: ;
			endcase
		end
	end

	// pipeline valid bits and stage moves
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic mv_1, mv_2, mv_3, mv_4;
	logic rdy_2, rdy_3, rdy_4, rdy_5;

	// a stage can take a word when empty or when its word moves on
	assign rdy_5    = !v_s5 || out_ready;
	assign mv_4     = v_s4 && rdy_5;
	assign rdy_4    = !v_s4 || mv_4;
	assign mv_3     = v_s3 && rdy_4;
	assign rdy_3    = !v_s3 || mv_3;
	assign mv_2     = v_s2 && rdy_3;
	assign rdy_2    = !v_s2 || mv_2;
	assign mv_1     = v_s1 && rdy_2;
	assign in_ready = !v_s1 || mv_1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (in_valid && in_ready) v_s1 <= 1'b1;
			else if (mv_1)            v_s1 <= 1'b0;
			if (mv_1)      v_s2 <= 1'b1;
			else if (mv_2) v_s2 <= 1'b0;
			if (mv_2)      v_s3 <= 1'b1;
			else if (mv_3) v_s3 <= 1'b0;
			if (mv_3)      v_s4 <= 1'b1;
			else if (mv_4) v_s4 <= 1'b0;
			if (mv_4)           v_s5 <= 1'b1;
			else if (out_ready) v_s5 <= 1'b0;
		end
	end

	// stage 1: input register
	logic signed [11:0] temp_s1;
	logic               level_s1, ign_s1;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			temp_s1  <= temperature;
			level_s1 <= level_ok;
			ign_s1   <= ignition_on;
		end
	end

	// stage 2: mode machine, timers and pid state step as the word leaves s1
	ctl_t    ctl_nxt, ctl_s2, ctl_s3, ctl_s4;
	pid_in_t pid_nxt, pid_s2;

	clc_mode_fsm u_fsm (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (mv_1),
		.temperature (temp_s1),
		.level_ok    (level_s1),
		.ignition_on (ign_s1),
		.cfg         (cfg_q),
		.ctl         (ctl_nxt),
		.pid_in      (pid_nxt)
	);

	always_ff @(posedge clk) begin
		if (mv_1) begin
			ctl_s2 <= ctl_nxt;
			pid_s2 <= pid_nxt;
		end
		// control rides alongside the pid products and sum
		if (mv_2) ctl_s3 <= ctl_s2;
		if (mv_3) ctl_s4 <= ctl_s3;
	end

	// stages 3 and 4: gain products, then the weighted sum and scaling
	logic [6:0] pid_speed;

	clc_pid_dp u_pid (
		.clk       (clk),
		.ld_s3     (mv_2),
		.ld_s4     (mv_3),
		.cfg       (cfg_q),
		.pid_in    (pid_s2),
		.pid_speed (pid_speed)
	);

	// stage 5: result register; fan_speed_s5 doubles as the held fan speed
	logic       pump_s5, fan_s5;
	logic [6:0] fan_speed_s5;
	logic [2:0] mode_s5;

	always_ff @(posedge clk) begin
		if (mv_4) begin
			pump_s5 <= ctl_s4.pump;
			fan_s5  <= ctl_s4.fan;
			mode_s5 <= ctl_s4.mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fan_speed_s5 <= 7'd0;
		end else if (mv_4) begin
			unique case (ctl_s4.spd_op)
				SPD_ZERO: fan_speed_s5 <= 7'd0;
				SPD_FULL: fan_speed_s5 <= SPEED_MAX;
				SPD_PID:  fan_speed_s5 <= pid_speed;
				default:  fan_speed_s5 <= fan_speed_s5;
			endcase
		end
	end

	assign out_valid = v_s5;
	assign pump_on   = pump_s5;
	assign fan_on    = fan_s5;
	assign fan_speed = fan_speed_s5;
	assign mode      = mode_s5;

	// checks
	`CLC_ASSERT_IMP(a_speed_cap, out_valid, fan_speed <= SPEED_MAX,
		"fan speed above 100 percent")
	`CLC_ASSERT_IMP(a_fan_off_still, out_valid && !fan_on, fan_speed == 7'd0,
		"fan off with nonzero speed")
	`CLC_ASSERT_IMP(a_mode_legal, out_valid, mode <= MODE_EMERG,
		"result mode code out of range")
	`CLC_ASSERT_NXT(a_in_capture, in_valid && in_ready, v_s1,
		"accepted word not held in input stage")

endmodule

// ===== verif/tb_coolant_loop_controller.sv =====
module tb_coolant_loop_controller;
	import clc_pkg::*;

	localparam int TEMP_LO     = -500;
	localparam int TEMP_HI     = 2000;
	localparam int SPEED_SCALE = 25600;
	localparam int CYCLE_LIMIT = 400000;

	// one result word as the block reports it
	typedef struct packed {
		logic       pump;
		logic       fan;
		logic [6:0] speed;
		logic [2:0] mode;
	} drive_word_t;

	// tracks the controller state per accepted tick and holds the words still due
	class coolant_tracker;
		int kp, ki, kd;
		int target, fan_start, fan_hyst, hot_limit, crit_limit;
		logic [2:0] cur_mode;
		bit pump, fan, low_armed, hot_armed;
		int speed, integ, prev_e;
		int pump_ticks, low_ticks, hot_ticks;
		drive_word_t due_words[$];
		int mismatches, checked;
		int mode_hits[5];

		function new();
			set_reg(REG_PROP_GAIN, 16'd640);
			set_reg(REG_INTEG_GAIN, 16'd128);
			set_reg(REG_DERIV_GAIN, 16'd26);
			set_reg(REG_TARGET_TEMP, 16'd650);
			set_reg(REG_FAN_START, 16'd600);
			set_reg(REG_FAN_HYST, 16'd50);
			set_reg(REG_MAX_TEMP, 16'd750);
			set_reg(REG_CRIT_TEMP, 16'd850);
			cur_mode = MODE_OFF;
		endfunction

		function void set_reg(logic [2:0] idx, logic [15:0] val);
			case (idx)
				REG_PROP_GAIN:   kp = val;
				REG_INTEG_GAIN:  ki = val;
				REG_DERIV_GAIN:  kd = val;
				REG_TARGET_TEMP: target = $signed(val[11:0]);
				REG_FAN_START:   fan_start = $signed(val[11:0]);
				REG_FAN_HYST:    fan_hyst = val[8:0];
				REG_MAX_TEMP:    hot_limit = $signed(val[11:0]);
				REG_CRIT_TEMP:   crit_limit = $signed(val[11:0]);
				default: ;
			endcase
		endfunction

		function int count_up(int c);
			return (c >= 255) ? 255 : c + 1;
		endfunction

		// fixed one-tick pid, speed in percent
		function int pid_speed(int t);
			int e;
			int acc;
			longint total;
			e = t - target;
			acc = integ + e;
			if (acc > int'(INTEG_LIMIT)) acc = int'(INTEG_LIMIT);
			if (acc < -int'(INTEG_LIMIT)) acc = -int'(INTEG_LIMIT);
			integ = acc;
			total = longint'(kp) * e * 10 + longint'(ki) * acc
				+ longint'(kd) * (e - prev_e) * 100;
			prev_e = e;
			if (total <= 0) return 0;
			total = total / SPEED_SCALE;
			return (total > int'(SPEED_MAX)) ? int'(SPEED_MAX) : int'(total);
		endfunction

		// low level, critical and over-temperature checks in running mode
		function bit checks_pass(int t, bit lvl);
			if (!lvl) begin
				if (!low_armed) begin
					low_armed = 1'b1;
					low_ticks = 0;
				end else if (low_ticks > int'(LOW_LEVEL_TICKS)) begin
					cur_mode = MODE_ERR;
					return 1'b0;
				end
			end else begin
				low_armed = 1'b0;
			end
			if (t > crit_limit) begin
				cur_mode = MODE_EMERG;
				return 1'b0;
			end
			if (t > hot_limit) begin
				if (!hot_armed) begin
					hot_armed = 1'b1;
					hot_ticks = 0;
				end else if (hot_ticks > int'(OVER_TEMP_TICKS)) begin
					cur_mode = MODE_ERR;
					return 1'b0;
				end
			end else begin
				hot_armed = 1'b0;
			end
			return 1'b1;
		endfunction

		function void note_tick(logic signed [11:0] temp_in, bit lvl, bit ign);
			int t;
			drive_word_t w;
			t = temp_in;
			if (low_armed) low_ticks = count_up(low_ticks);
			if (hot_armed) hot_ticks = count_up(hot_ticks);
			case (cur_mode)
				MODE_INIT: begin
					if (!lvl) begin
						cur_mode = MODE_ERR;
					end else begin
						if (!pump) begin
							pump = 1'b1;
							pump_ticks = 0;
						end else begin
							pump_ticks = count_up(pump_ticks);
						end
						if (pump_ticks > int'(INIT_TICKS)) cur_mode = MODE_RUN;
					end
				end
				MODE_RUN: begin
					if (!ign) begin
						cur_mode = MODE_OFF;
					end else if (checks_pass(t, lvl)) begin
						pump = 1'b1;
						if (t > fan_start) begin
							fan = 1'b1;
							speed = pid_speed(t);
						end else if (t < fan_start - fan_hyst) begin
							fan = 1'b0;
							speed = 0;
							integ = 0;
							prev_e = 0;
						end
					end
				end
				MODE_ERR: begin
					pump = 1'b0;
					fan = 1'b0;
					speed = 0;
					if (lvl && t < hot_limit) cur_mode = ign ? MODE_INIT : MODE_OFF;
				end
				MODE_EMERG: begin
					pump = 1'b0;
					fan = 1'b1;
					speed = int'(SPEED_MAX);
					if (t < hot_limit) cur_mode = MODE_ERR;
				end
				default: begin
					pump = 1'b0;
					fan = 1'b0;
					speed = 0;
					cur_mode = ign ? MODE_INIT : MODE_OFF;
				end
			endcase
			w.pump = pump;
			w.fan = fan;
			w.speed = 7'(speed);
			w.mode = cur_mode;
			due_words.push_back(w);
		endfunction

		function void check_word(logic p, logic f, logic [6:0] s, logic [2:0] m);
			drive_word_t w;
			if (due_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: pump %b fan %b speed %0d mode %0d",
						p, f, s, m);
				return;
			end
			w = due_words.pop_front();
			checked++;
			if (w.mode <= MODE_EMERG) mode_hits[w.mode]++;
			if (w.pump !== p || w.fan !== f || w.speed !== s || w.mode !== m) begin
				mismatches++;
				if (mismatches <= 10)
					$display("word %0d: expected pump %b fan %b speed %0d mode %0d, %s%b %s%b %s%0d %s%0d",
						checked, w.pump, w.fan, w.speed, w.mode,
						"got pump ", p, "fan ", f, "speed ", s, "mode ", m);
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic signed [11:0] temperature;
	logic              level_ok;
	logic              ignition_on;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              pump_on;
	logic              fan_on;
	logic [6:0]        fan_speed;
	logic [2:0]        mode;
	logic              cfg_we;
	logic [2:0]        cfg_index;
	logic [15:0]       cfg_data;

	coolant_tracker book;
	int  items_sent   = 0;
	int  phases_run   = 0;
	int  cycle_count  = 0;
	int  rx_stall     = 0;
	bit  quiet        = 1'b0;
	bit  tx_idle_on   = 1'b1;
	bit  rx_idle_on   = 1'b1;

	coolant_loop_controller u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.temperature (temperature),
		.level_ok    (level_ok),
		.ignition_on (ignition_on),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pump_on     (pump_on),
		.fan_on      (fan_on),
		.fan_speed   (fan_speed),
		.mode        (mode),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// 8 time unit clock
	always #4 clk = ~clk;

	// hard stop if the run hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[coolant_loop_controller] ERROR");
			$finish;
		end
	end

	// both handshakes are sampled at the rising edge; inputs only move on the falling one
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) book.note_tick(temperature, level_ok, ignition_on);
			if (out_valid && out_ready) book.check_word(pump_on, fan_on, fan_speed, mode);
		end
	end

	// result side back-pressure: random stall bursts
	always @(negedge clk) begin
		if (rx_stall > 0) begin
			out_ready <= 1'b0;
			rx_stall <= rx_stall - 1;
		end else if (!quiet && rx_idle_on && $urandom_range(0, 9) == 0) begin
			out_ready <= 1'b0;
			rx_stall <= $urandom_range(0, 18);
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic int clamp_temp(int v);
		return (v < TEMP_LO) ? TEMP_LO : ((v > TEMP_HI) ? TEMP_HI : v);
	endfunction

	function automatic int pick(int lo, int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	// one tick word; valid stays up across back-to-back words and drops only for gaps
	task automatic send_tick(input int t, input bit lvl, input bit ign);
		if (!quiet && tx_idle_on && $urandom_range(0, 11) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_valid    <= 1'b1;
		temperature <= 12'(t);
		level_ok    <= lvl;
		ignition_on <= ign;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		items_sent++;
	endtask

	// hold off the sender until every due word has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (book.due_words.size() != 0) @(negedge clk);
	endtask

	// write all eight registers back to back while the block is idle
	task automatic program_config(input int vals[8]);
		for (int i = 0; i < 8; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data  <= 16'(vals[i]);
			@(negedge clk);
			book.set_reg(3'(i), 16'(vals[i]));
		end
		cfg_we <= 1'b0;
		phases_run++;
	endtask

	// one stretch of plant behavior, shaped around the current limits
	task automatic run_episode();
		int kind, len, t, lo, hi;
		kind = $urandom_range(0, 11);
		case (kind)
			0, 1, 2, 3, 4: begin
				// normal driving, temperature wanders through the fan band
				len = pick(30, 90);
				t = clamp_temp(book.fan_start + pick(-100, 100));
				repeat (len) begin
					t = clamp_temp(t + pick(-15, 15));
					send_tick(t, $urandom_range(0, 30) != 0, $urandom_range(0, 60) != 0);
				end
			end
			5, 6: begin
				// coolant level low long enough to trip the level timer or not
				len = pick(20, 45);
				repeat (len) send_tick(clamp_temp(book.fan_start + pick(-60, 60)), 1'b0, 1'b1);
			end
			7: begin
				// hot but below critical, sometimes long enough to trip the over-temperature timer
				lo = clamp_temp(book.hot_limit + 1);
				hi = clamp_temp(book.crit_limit);
				if (hi < lo) hi = lo;
				len = pick(95, 115);
				repeat (len) send_tick(pick(lo, hi), 1'b1, 1'b1);
			end
			8: begin
				// critical spike then cool-down out of emergency stop
				lo = clamp_temp(book.crit_limit + 1);
				repeat (pick(2, 4)) send_tick(pick(lo, TEMP_HI), 1'b1, 1'b1);
				hi = clamp_temp(book.hot_limit - 1);
				repeat (pick(5, 15)) send_tick(pick(TEMP_LO, hi), 1'b1, 1'b1);
			end
			9: begin
				// ignition off
				repeat (pick(2, 8))
					send_tick(pick(TEMP_LO, TEMP_HI), $urandom_range(0, 1), 1'b0);
			end
			10: begin
				// unstructured noise
				repeat (pick(5, 20))
					send_tick(pick(TEMP_LO, TEMP_HI), $urandom_range(0, 1),
						$urandom_range(0, 1));
			end
			default: begin
				// cool clean start-up, long enough to reach running
				hi = clamp_temp(book.hot_limit - 1);
				repeat (25) send_tick(pick(TEMP_LO, hi), 1'b1, 1'b1);
			end
		endcase
	endtask

	initial begin
		int vals[8];
		int base;
		int goal;
		book        = new();
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		temperature = '0;
		level_ok    = 1'b0;
		ignition_on = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed walk on reset limits: off, init, low level to error,
		// recovery, full pump spin-up into running, then a critical spike
		send_tick(TEMP_LO, 1'b1, 1'b0);
		send_tick(650, 1'b1, 1'b1);
		send_tick(TEMP_HI, 1'b0, 1'b1);
		send_tick(TEMP_LO, 1'b1, 1'b1);
		repeat (22) send_tick(550, 1'b1, 1'b1);
		send_tick(TEMP_HI, 1'b1, 1'b1);

		goal = items_sent + 75;
		while (items_sent < goal) run_episode();

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			if (ph == 0) begin
				// full gains, lowest setpoints, widest band, highest limits
				vals[REG_PROP_GAIN]   = 65535;
				vals[REG_INTEG_GAIN]  = 65535;
				vals[REG_DERIV_GAIN]  = 65535;
				vals[REG_TARGET_TEMP] = TEMP_LO;
				vals[REG_FAN_START]   = TEMP_LO;
				vals[REG_FAN_HYST]    = 500;
				vals[REG_MAX_TEMP]    = TEMP_HI;
				vals[REG_CRIT_TEMP]   = TEMP_HI;
			end else if (ph == 1) begin
				// zero gains but derivative, highest setpoints, no band, lowest limits
				vals[REG_PROP_GAIN]   = 0;
				vals[REG_INTEG_GAIN]  = 0;
				vals[REG_DERIV_GAIN]  = 65535;
				vals[REG_TARGET_TEMP] = TEMP_HI;
				vals[REG_FAN_START]   = TEMP_HI;
				vals[REG_FAN_HYST]    = 0;
				vals[REG_MAX_TEMP]    = TEMP_LO;
				vals[REG_CRIT_TEMP]   = TEMP_LO;
			end else begin
				base = pick(-200, 1300);
				vals[REG_PROP_GAIN]  = ($urandom_range(0, 3) == 0) ? pick(0, 65535) : pick(0, 3000);
				vals[REG_INTEG_GAIN] = ($urandom_range(0, 3) == 0) ? pick(0, 65535) : pick(0, 1000);
				vals[REG_DERIV_GAIN] = ($urandom_range(0, 3) == 0) ? pick(0, 65535) : pick(0, 500);
				vals[REG_TARGET_TEMP] = clamp_temp(base + pick(-50, 150));
				vals[REG_FAN_START]   = clamp_temp(base);
				vals[REG_FAN_HYST]    = ($urandom_range(0, 2) == 0) ? pick(0, 500) : pick(0, 80);
				vals[REG_MAX_TEMP]    = clamp_temp(base + pick(30, 250));
				vals[REG_CRIT_TEMP]   = clamp_temp(vals[REG_MAX_TEMP] + pick(1, 200));
			end
			program_config(vals);
			// the last phase runs flat out on both sides
			quiet      = (ph == 7);
			tx_idle_on = $urandom_range(0, 3) != 0;
			rx_idle_on = $urandom_range(0, 3) != 0;
			goal = items_sent + 75;
			while (items_sent < goal) run_episode();
		end

		drain();
		repeat (8) @(negedge clk);
		$display("%0d tick words sent, %0d result words checked, %0d register settings",
			items_sent, book.checked, phases_run + 1);
		$display("results seen per mode: off %0d init %0d run %0d error %0d emergency %0d",
			book.mode_hits[MODE_OFF], book.mode_hits[MODE_INIT], book.mode_hits[MODE_RUN],
			book.mode_hits[MODE_ERR], book.mode_hits[MODE_EMERG]);
		if (book.mismatches == 0 && book.due_words.size() == 0) begin
			$display("[coolant_loop_controller] OK");
		end else begin
			$display("[coolant_loop_controller] ERROR");
		end
		$finish;
	end

endmodule
